// ===== hdl/mpd_pkg.sv =====
package mpd_pkg;

  // Configuration port geometry
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ScaleW   = 4;
  localparam logic [ScaleW-1:0] ScaleReset = 4'd2;

  // Word index of each register (paddr[2])
  localparam logic RegIdxScale = 1'b0;

  // Header byte bit positions
  localparam int unsigned HdrSyncBit  = 3;
  localparam int unsigned HdrXSignBit = 4;
  localparam int unsigned HdrYSignBit = 5;
  localparam int unsigned BtnW        = 3;

  // Scaled movement width: 9-bit signed times 4-bit unsigned, plus one for negation
  localparam int unsigned MoveW = 15;

  localparam logic [15:0] PosMax = 16'hFFFF;

  // Input word operations
  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Position of the next byte within a packet
  typedef enum logic [1:0] {
    IDX_FIRST  = 2'd0,
    IDX_SECOND = 2'd1,
    IDX_THIRD  = 2'd2
  } byte_idx_e;

  typedef struct packed {
    byte_idx_e          byte_idx;
    logic [7:0]         first_byte;
    logic [7:0]         second_byte;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic [BtnW-1:0]    buttons;
  } mpd_state_t;

  typedef struct packed {
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic [BtnW-1:0]    buttons;
    logic               has_delta;
    logic               packet_done;
  } mpd_result_t;

  // Saturating add of a small movement onto a 32-bit accumulator
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [MoveW-1:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = $signed({a[31], a}) + $signed({{(33-MoveW){b[MoveW-1]}}, b});
    if (s[32] != s[31]) begin
      r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // Clamp an accumulator to the 16-bit screen range
  function automatic logic [15:0] clamp_pos(input logic signed [31:0] v);
    logic [15:0] r;
    if (v[31]) begin
      r = 16'd0;
    end else if (|v[30:16]) begin
      r = PosMax;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/mouse_packet_decoder_top.sv =====
// Channel | Handshake             | Fields
// --------+-----------------------+--------------------------------------------------
// in      | in_valid_i/in_ready_o | op_i, rx_byte_i, load_x_i, load_y_i
// out     | out_valid_o/out_ready_i | pos_x_o, pos_y_o, delta_x_o, delta_y_o, buttons_o,
//         |                       | has_delta_o, packet_done_o
// cfg     | APB (psel, penable)   | paddr, pwdata, prdata; motion_scale at 0x0
//
// Result valid follows input accept via the input register, then the result register.
// Sustains one word per cycle while the result is not stalled; the state update
// sits between the two registers.
// Reset clears the packet position, accumulators, buttons and both valid flags;
// motion_scale resets to 2.
// A stalled result holds the pipe; an empty input register still takes one more word.
module mouse_packet_decoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // APB configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpd_pkg::CfgAddrW-1:0]   paddr,
  input  logic [mpd_pkg::CfgDataW-1:0]   pwdata,
  output logic [mpd_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     op_i,
  input  logic [7:0]                     rx_byte_i,
  input  logic [15:0]                    load_x_i,
  input  logic [15:0]                    load_y_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [15:0]                    pos_x_o,
  output logic [15:0]                    pos_y_o,
  output logic signed [31:0]             delta_x_o,
  output logic signed [31:0]             delta_y_o,
  output logic [2:0]                     buttons_o,
  output logic                           has_delta_o,
  output logic                           packet_done_o
);
  import mpd_pkg::*;

  logic [ScaleW-1:0] scale;

  logic        in_vld_q;
  logic [1:0]  op_q;
  logic [7:0]  rx_q;
  logic [15:0] load_x_q, load_y_q;
  logic        advance;
  logic        in_take;

  mpd_state_t  state_q, state_d;
  mpd_result_t res_q, res_d;
  logic        out_vld_q;

  assign pready = 1'b1;

  mpd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .scale_o   (scale)
  );

  // Pipe control
  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;
  assign in_take    = in_valid_i & in_ready_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q     <= op_i;
      rx_q     <= rx_byte_i;
      load_x_q <= load_x_i;
      load_y_q <= load_y_i;
    end
  end

  mpd_update u_update (
    .state_i   (state_q),
    .op_i      (op_q),
    .rx_byte_i (rx_q),
    .load_x_i  (load_x_q),
    .load_y_i  (load_y_q),
    .scale_i   (scale),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign pos_x_o       = res_q.pos_x;
  assign pos_y_o       = res_q.pos_y;
  assign delta_x_o     = res_q.delta_x;
  assign delta_y_o     = res_q.delta_y;
  assign buttons_o     = res_q.buttons;
  assign has_delta_o   = res_q.has_delta;
  assign packet_done_o = res_q.packet_done;

`ifndef SYNTHESIS
  // A completed packet always leaves the byte position back at the header
  a_done_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.packet_done |=> state_q.byte_idx == IDX_FIRST)
    else $error("packet_done without byte position reset");

  // Only a received byte can complete a packet
  a_done_only_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (op_q != OP_BYTE) |=> !packet_done_o)
    else $error("packet_done on a non-byte word");

  // Pending-delta flag agrees with the delivered accumulators
  a_has_delta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> has_delta_o == ((delta_x_o != '0) || (delta_y_o != '0)))
    else $error("has_delta mismatch");

  // Decoder state only moves when a word is retired
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a retired word");
`endif

endmodule

// ===== hdl/mpd_cfg.sv =====
module mpd_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic [mpd_pkg::CfgAddrW-1:0]   paddr_i,
  input  logic [mpd_pkg::CfgDataW-1:0]   pwdata_i,
  output logic [mpd_pkg::CfgDataW-1:0]   prdata_o,
  output logic [mpd_pkg::ScaleW-1:0]     scale_o
);
  import mpd_pkg::*;

  logic [ScaleW-1:0] scale_q, scale_d;
  logic              wr_en;

  // Write strobe on the access phase
  assign wr_en = psel_i & penable_i & pwrite_i;

  always_comb begin
    scale_d = scale_q;
    if (wr_en && (paddr_i[2] == RegIdxScale)) begin
      scale_d = pwdata_i[ScaleW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
    end else begin
      scale_q <= scale_d;
    end
  end

  // Read mux
  always_comb begin
    prdata_o = '0;
    if (paddr_i[2] == RegIdxScale) begin
      prdata_o = {{(CfgDataW-ScaleW){1'b0}}, scale_q};
    end
  end

  assign scale_o = scale_q;

endmodule

// ===== hdl/mpd_motion.sv =====
module mpd_motion (
  input  logic [7:0]                        hdr_i,
  input  logic [7:0]                        x_byte_i,
  input  logic [7:0]                        y_byte_i,
  input  logic [mpd_pkg::ScaleW-1:0]        scale_i,
  output logic signed [mpd_pkg::MoveW-1:0]  move_x_o,
  output logic signed [mpd_pkg::MoveW-1:0]  move_y_o
);
  import mpd_pkg::*;

  logic signed [8:0]  raw_x, raw_y;
  logic signed [13:0] ext_x, ext_y, ext_s;
  logic signed [13:0] mul_x, mul_y;

  // 9-bit two's complement movement, sign from the header
  assign raw_x = {hdr_i[HdrXSignBit], x_byte_i};
  assign raw_y = {hdr_i[HdrYSignBit], y_byte_i};

  assign ext_x = {{5{raw_x[8]}}, raw_x};
  assign ext_y = {{5{raw_y[8]}}, raw_y};
  assign ext_s = {10'd0, scale_i};

  assign mul_x = ext_x * ext_s;
  assign mul_y = ext_y * ext_s;

  // Y is inverted so screen downward is positive
  assign move_x_o = {mul_x[13], mul_x};
  assign move_y_o = -$signed({mul_y[13], mul_y});

endmodule

// ===== hdl/mpd_update.sv =====
module mpd_update (
  input  mpd_pkg::mpd_state_t          state_i,
  input  logic [1:0]                   op_i,
  input  logic [7:0]                   rx_byte_i,
  input  logic [15:0]                  load_x_i,
  input  logic [15:0]                  load_y_i,
  input  logic [mpd_pkg::ScaleW-1:0]   scale_i,
  output mpd_pkg::mpd_state_t          state_o,
  output mpd_pkg::mpd_result_t         result_o
);
  import mpd_pkg::*;

  logic signed [MoveW-1:0] move_x, move_y;
  byte_idx_e               idx_d;
  logic                    pkt_end;
  logic                    pkt_ok;

  mpd_motion u_motion (
    .hdr_i    (state_i.first_byte),
    .x_byte_i (state_i.second_byte),
    .y_byte_i (rx_byte_i),
    .scale_i  (scale_i),
    .move_x_o (move_x),
    .move_y_o (move_y)
  );

  assign pkt_end = (op_i == OP_BYTE) && (state_i.byte_idx == IDX_THIRD);
  assign pkt_ok  = pkt_end && state_i.first_byte[HdrSyncBit];

  // Byte position next state
  always_comb begin
    idx_d = state_i.byte_idx;
    if (op_i == OP_BYTE) begin
      unique case (state_i.byte_idx)
        IDX_FIRST:  idx_d = IDX_SECOND;
        IDX_SECOND: idx_d = IDX_THIRD;
        default:    idx_d = IDX_FIRST;
      endcase
    end
  end

  // Datapath state update
  always_comb begin
    state_o          = state_i;
    state_o.byte_idx = idx_d;
    unique case (op_i)
      OP_BYTE: begin
        if (state_i.byte_idx == IDX_FIRST) begin
          state_o.first_byte = rx_byte_i;
        end else if (state_i.byte_idx == IDX_SECOND) begin
          state_o.second_byte = rx_byte_i;
        end else if (pkt_ok) begin
          state_o.buttons = state_i.first_byte[BtnW-1:0];
          state_o.delta_x = sat_add(state_i.delta_x, move_x);
          state_o.delta_y = sat_add(state_i.delta_y, move_y);
          state_o.pos_x   = sat_add(state_i.pos_x, move_x);
          state_o.pos_y   = sat_add(state_i.pos_y, move_y);
        end
      end
      OP_LOAD: begin
        state_o.pos_x = {16'd0, load_x_i};
        state_o.pos_y = {16'd0, load_y_i};
      end
      OP_CLEAR: begin
        state_o.delta_x = '0;
        state_o.delta_y = '0;
      end
      default: ;
    endcase
  end

  // Result word reflects the state after this word
  always_comb begin
    result_o.pos_x       = clamp_pos(state_o.pos_x);
    result_o.pos_y       = clamp_pos(state_o.pos_y);
    result_o.delta_x     = state_o.delta_x;
    result_o.delta_y     = state_o.delta_y;
    result_o.buttons     = state_o.buttons;
    result_o.has_delta   = (state_o.delta_x != '0) || (state_o.delta_y != '0);
    result_o.packet_done = pkt_ok;
  end

endmodule
